FILE: rtl/core/fmsi_pkg.sv
`default_nettype none
package fmsi_pkg;
  localparam int FrameLen = 32;
  localparam int PosW = $clog2(FrameLen);
  localparam int CntW = $clog2(FrameLen + 1);
  localparam int SumW = 16 + CntW;

  typedef enum logic [1:0] {
    MODE_MEAN = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_FFILL = 2'd2,
    MODE_BFILL = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic missing;
  } entry_t;

  typedef struct packed {
    logic start;
    logic signed [SumW-1:0] sum;
    logic [CntW-1:0] count;
  } frame_info_t;
endpackage
`default_nettype wire

FILE: rtl/core/fmsi_sample_if.sv
`default_nettype none
interface fmsi_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample_value;
  logic sample_missing;
  modport source (output valid, sample_value, sample_missing, input ready);
  modport sink (input valid, sample_value, sample_missing, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fmsi_result_if.sv
`default_nettype none
interface fmsi_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] filled_value;
  logic still_missing;
  logic frame_end;
  modport source (output valid, filled_value, still_missing, frame_end, input ready);
  modport sink (input valid, filled_value, still_missing, frame_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fmsi_divider.sv
`default_nettype none
module fmsi_divider import fmsi_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic signed [31:0] dividend,
  input wire logic [CntW-1:0] divisor,
  output logic busy,
  output logic done,
  output logic signed [31:0] quotient
);
  logic [31:0] rem_mag;
  logic [31:0] quo;
  logic [CntW-1:0] den;
  logic negative;
  logic [5:0] bit_left;
  logic [32:0] trial;

  assign trial = {rem_mag[31:0], quo[31]} - {{(33-CntW){1'b0}}, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bit_left <= 6'd32;
        rem_mag <= '0;
        quo <= dividend[31] ? 32'(-dividend) : dividend;
        negative <= dividend[31];
        den <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem_mag <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem_mag <= {rem_mag[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        bit_left <= bit_left - 6'd1;
        if (bit_left == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = negative ? 32'(-quo) : quo;
endmodule
`default_nettype wire

FILE: rtl/core/fmsi_loader.sv
`default_nettype none
module fmsi_loader import fmsi_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic enable,
  fmsi_sample_if.sink in_ch,
  output logic wr_en,
  output logic [PosW-1:0] wr_addr,
  output entry_t wr_data,
  output frame_info_t info
);
  logic [PosW-1:0] position;
  logic signed [SumW-1:0] sum;
  logic [CntW-1:0] count;
  logic fire;

  assign in_ch.ready = enable;
  assign fire = in_ch.valid && enable;
  assign wr_en = fire;
  assign wr_addr = position;
  assign wr_data.value = in_ch.sample_missing ? 16'sd0 : in_ch.sample_value;
  assign wr_data.missing = in_ch.sample_missing;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      sum <= '0;
      count <= '0;
      info <= '0;
    end else begin
      info.start <= 1'b0;
      if (fire) begin
        if (position == PosW'(FrameLen - 1)) begin
          position <= '0;
          sum <= '0;
          count <= '0;
          info.start <= 1'b1;
          info.sum <= in_ch.sample_missing ? sum : sum + SumW'(in_ch.sample_value);
          info.count <= in_ch.sample_missing ? count : count + CntW'(1);
        end else begin
          position <= position + PosW'(1);
          if (!in_ch.sample_missing) begin
            sum <= sum + SumW'(in_ch.sample_value);
            count <= count + CntW'(1);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/frame_missing_sample_imputer_top.sv
// Loading writes each accepted sample to memory; the fill starts in the cycle after
// the last sample. Mean mode runs at most one divide per frame; forward and backward
// fill read each position once; linear mode probes memory to both sides of each gap
// and runs one divide for each position that it fills. Emit reads each entry and presents
// it as a result once the sink can take it; input is held off outside the load state.
// Synchronous active-high reset clears control state and sets mode to 0.
`default_nettype none
module frame_missing_sample_imputer_top import fmsi_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_data,
  fmsi_sample_if.sink samples,
  fmsi_result_if.source results
);
  typedef enum logic [9:0] {
    S_LOAD = 10'b0000000001,
    S_MEAN = 10'b0000000010,
    S_SCAN = 10'b0000000100,
    S_SCAN_W = 10'b0000001000,
    S_LEFT = 10'b0000010000,
    S_RIGHT = 10'b0000100000,
    S_DIV = 10'b0001000000,
    S_COPY = 10'b0010000000,
    S_EMIT = 10'b0100000000,
    S_EMIT_W = 10'b1000000000
  } state_t;

  state_t state;
  mode_t mode;
  entry_t mem [FrameLen];
  entry_t rd_data;
  logic [PosW-1:0] rd_addr;
  logic rd_en;
  logic m_we;
  logic [PosW-1:0] m_waddr;
  entry_t m_wdata;
  logic ld_we;
  logic [PosW-1:0] ld_addr;
  entry_t ld_data;
  frame_info_t info;

  logic [PosW:0] idx;
  logic [PosW:0] probe;
  logic [PosW:0] lo_pos;
  entry_t prev;
  entry_t cur;
  logic signed [15:0] lo_val;
  logic signed [15:0] mean_val;
  logic div_start;
  logic signed [31:0] dividend;
  logic [CntW-1:0] divisor;
  logic div_busy;
  logic div_done;
  logic signed [31:0] quotient;
  logic last_sent;

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_MEAN;
    else if (cfg_we) mode <= mode_t'(cfg_data);
  end

  fmsi_loader u_loader (
    .clk(clk), .rst(rst), .enable(state == S_LOAD && !info.start),
    .in_ch(samples), .wr_en(ld_we), .wr_addr(ld_addr), .wr_data(ld_data), .info(info)
  );

  fmsi_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend), .divisor(divisor),
    .busy(div_busy), .done(div_done), .quotient(quotient)
  );

  logic p_we;
  logic [PosW-1:0] p_waddr;
  entry_t p_wdata;
  assign m_we = ld_we | p_we;
  assign m_waddr = ld_we ? ld_addr : p_waddr;
  assign m_wdata = ld_we ? ld_data : p_wdata;

  always_ff @(posedge clk) begin
    if (m_we) mem[m_waddr] <= m_wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign cur = (mode == MODE_MEAN && rd_data.missing) ? {mean_val, 1'b0} : rd_data;

  // Main sequencer: read one entry, then decide.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      div_start <= 1'b0;
      p_we <= 1'b0;
      rd_en <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      p_we <= 1'b0;
      rd_en <= 1'b0;
      if (results.valid && results.ready) results.valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (info.start) begin
            idx <= '0;
            dividend <= 32'(info.sum);
            divisor <= info.count;
            if (mode == MODE_MEAN) begin
              if (info.count == '0) begin
                mean_val <= '0;
                state <= S_EMIT;
              end else begin
                div_start <= 1'b1;
                state <= S_MEAN;
              end
            end else if (mode == MODE_LINEAR) begin
              idx <= (PosW+1)'(1);
              state <= S_SCAN;
            end else begin
              idx <= (mode == MODE_FFILL) ? '0 : (PosW+1)'(FrameLen - 1);
              state <= S_COPY;
              rd_addr <= (mode == MODE_FFILL) ? '0 : PosW'(FrameLen - 1);
              rd_en <= 1'b1;
              probe <= '0;
            end
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_val <= quotient[15:0];
            state <= S_EMIT;
          end
        end
        S_COPY: begin
          // probe counts steps; first step only latches the end entry.
          if (!rd_en) begin
            if (probe == '0) prev <= rd_data;
            else if (rd_data.missing) begin
              p_we <= 1'b1;
              p_waddr <= idx[PosW-1:0];
              p_wdata <= prev;
            end else prev <= rd_data;
            if (probe == (PosW+1)'(FrameLen - 1)) begin
              idx <= '0;
              state <= S_EMIT;
            end else begin
              probe <= probe + 1'b1;
              if (mode == MODE_FFILL) begin
                idx <= idx + 1'b1;
                rd_addr <= PosW'(idx + 1'b1);
              end else begin
                idx <= idx - 1'b1;
                rd_addr <= PosW'(idx - 1'b1);
              end
              rd_en <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (idx == (PosW+1)'(FrameLen - 1)) begin
            idx <= '0;
            state <= S_EMIT;
          end else begin
            rd_addr <= PosW'(idx);
            rd_en <= 1'b1;
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          if (!rd_en) begin
            if (!rd_data.missing) begin
              idx <= idx + 1'b1;
              state <= S_SCAN;
            end else begin
              probe <= idx - 1'b1;
              rd_addr <= PosW'(idx - 1'b1);
              rd_en <= 1'b1;
              state <= S_LEFT;
            end
          end
        end
        S_LEFT: begin
          if (!rd_en) begin
            if (!rd_data.missing) begin
              lo_pos <= probe;
              lo_val <= rd_data.value;
              probe <= idx + 1'b1;
              rd_addr <= PosW'(idx + 1'b1);
              rd_en <= 1'b1;
              state <= S_RIGHT;
            end else if (probe == '0) begin
              idx <= idx + 1'b1;
              state <= S_SCAN;
            end else begin
              probe <= probe - 1'b1;
              rd_addr <= PosW'(probe - 1'b1);
              rd_en <= 1'b1;
            end
          end
        end
        S_RIGHT: begin
          if (!rd_en) begin
            if (!rd_data.missing) begin
              dividend <= 32'((32'(rd_data.value) - 32'(lo_val))
                              * $signed({1'b0, idx - lo_pos}));
              divisor <= CntW'(probe - lo_pos);
              div_start <= 1'b1;
              state <= S_DIV;
            end else if (probe == (PosW+1)'(FrameLen - 1)) begin
              idx <= idx + 1'b1;
              state <= S_SCAN;
            end else begin
              probe <= probe + 1'b1;
              rd_addr <= PosW'(probe + 1'b1);
              rd_en <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            p_we <= 1'b1;
            p_waddr <= PosW'(idx);
            p_wdata.value <= lo_val + quotient[15:0];
            p_wdata.missing <= 1'b0;
            idx <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (!results.valid || results.ready) begin
            rd_addr <= PosW'(idx);
            rd_en <= 1'b1;
            state <= S_EMIT_W;
          end
        end
        S_EMIT_W: begin
          if (!rd_en && (!results.valid || results.ready)) begin
            results.valid <= 1'b1;
            results.filled_value <= cur.missing ? 16'sd0 : cur.value;
            results.still_missing <= cur.missing;
            results.frame_end <= (idx == (PosW+1)'(FrameLen - 1));
            if (idx == (PosW+1)'(FrameLen - 1)) begin
              state <= S_LOAD;
            end else begin
              idx <= idx + 1'b1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign last_sent = results.valid && results.ready && results.frame_end;

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !samples.ready)
    else $error("sample accepted outside load");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=> results.valid && $stable(results.filled_value))
    else $error("result dropped");
  a_end_once: assert property (@(posedge clk) disable iff (rst)
    last_sent |=> !(results.valid && results.frame_end))
    else $error("frame end sent twice");
endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fmsi_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_data = MODE_MEAN;

  fmsi_sample_if samples();
  fmsi_result_if results();

  frame_missing_sample_imputer_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .samples(samples),
    .results(results)
  );

  typedef struct packed {
    logic signed [15:0] value;
    logic gap;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic still_missing;
    logic frame_end;
  } filled_t;

  sample_t pending_samples[$];
  filled_t expected_filled[$];
  mode_t fill_mode = MODE_MEAN;
  sample_t frame_buf[FrameLen];
  int load_pos = 0;
  int present_sum = 0;
  int present_count = 0;

  int errors = 0;
  int accepted_samples = 0;
  int checked_results = 0;
  int frames_done = 0;
  int quiet_cycles = 0;
  int sink_hold = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;
  bit source_pause = 1'b0;

  always #10 clk = ~clk;

  task automatic impute_frame();
    int m;
    int lo;
    int hi;
    int a;
    int b;
    filled_t r;
    case (fill_mode)
      MODE_MEAN: begin
        m = (present_count > 0) ? present_sum / present_count : 0;
        for (int i = 0; i < FrameLen; i++) begin
          if (frame_buf[i].gap) begin
            frame_buf[i].value = 16'(m);
            frame_buf[i].gap = 1'b0;
          end
        end
      end
      MODE_LINEAR: begin
        for (int i = 1; i < FrameLen - 1; i++) begin
          if (frame_buf[i].gap) begin
            lo = i - 1;
            hi = i + 1;
            while (lo >= 0 && frame_buf[lo].gap) lo--;
            while (hi < FrameLen && frame_buf[hi].gap) hi++;
            if (lo >= 0 && hi < FrameLen) begin
              a = frame_buf[lo].value;
              b = frame_buf[hi].value;
              frame_buf[i].value = 16'(a + ((b - a) * (i - lo)) / (hi - lo));
              frame_buf[i].gap = 1'b0;
            end
          end
        end
      end
      MODE_FFILL: begin
        for (int i = 1; i < FrameLen; i++) begin
          if (frame_buf[i].gap) frame_buf[i] = frame_buf[i - 1];
        end
      end
      default: begin
        for (int i = FrameLen - 2; i >= 0; i--) begin
          if (frame_buf[i].gap) frame_buf[i] = frame_buf[i + 1];
        end
      end
    endcase
    for (int i = 0; i < FrameLen; i++) begin
      r.value = frame_buf[i].gap ? 16'sd0 : frame_buf[i].value;
      r.still_missing = frame_buf[i].gap;
      r.frame_end = (i == FrameLen - 1);
      expected_filled.push_back(r);
    end
  endtask

  task automatic load_sample(sample_t s);
    frame_buf[load_pos].gap = s.gap;
    frame_buf[load_pos].value = s.gap ? 16'sd0 : s.value;
    if (!s.gap) begin
      present_sum += s.value;
      present_count++;
    end
    if (load_pos == FrameLen - 1) begin
      impute_frame();
      load_pos = 0;
      present_sum = 0;
      present_count = 0;
    end else begin
      load_pos++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        load_sample('{samples.sample_value, samples.sample_missing});
        accepted_samples++;
        void'(pending_samples.pop_front());
      end
      if (pending_samples.size() > 0 && !source_pause
          && (calm || $urandom_range(99) >= 23)) begin
        samples.valid <= 1'b1;
        samples.sample_value <= pending_samples[0].value;
        samples.sample_missing <= pending_samples[0].gap;
      end else if (!(samples.valid && !samples.ready)) begin
        samples.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        checked_results++;
        if (expected_filled.size() == 0) begin
          $display("%0t: unexpected result value=%0d missing=%0b end=%0b", $time,
                   results.filled_value, results.still_missing, results.frame_end);
          errors++;
        end else begin
          if (results.filled_value !== expected_filled[0].value
              || results.still_missing !== expected_filled[0].still_missing
              || results.frame_end !== expected_filled[0].frame_end) begin
            $display("%0t: mismatch expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                     $time, expected_filled[0].value, expected_filled[0].still_missing,
                     expected_filled[0].frame_end, results.filled_value,
                     results.still_missing, results.frame_end);
            errors++;
          end
          if (expected_filled[0].frame_end) frames_done++;
          void'(expected_filled.pop_front());
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        sink_hold <= 300;
        results.ready <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        results.ready <= 1'b0;
      end else begin
        results.ready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((samples.valid && samples.ready) || (results.valid && results.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 20000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic sample_t rand_sample(int gap_pct);
    sample_t s;
    s.gap = ($urandom_range(99) < gap_pct);
    case ($urandom_range(5))
      0: s.value = 16'sh7fff;
      1: s.value = 16'sh8000;
      2: s.value = -16'sd1;
      default: s.value = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic drain();
    while (pending_samples.size() > 0 || expected_filled.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_mode(mode_t m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    fill_mode = m;
  endtask

  task automatic queue_frame(int gap_pct);
    for (int i = 0; i < FrameLen; i++) pending_samples.push_back(rand_sample(gap_pct));
  endtask

  initial begin
    sample_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < FrameLen; i++) begin
      s.gap = (i == 0 || i == 3 || i == 4 || i == 5 || i == FrameLen - 1);
      s.value = (i == 1) ? 16'sh7fff : (i == 2) ? 16'sh8000 : (i == 6) ? -16'sd1 : 16'sd5;
      if (i == 3) s.value = -16'sd1;
      pending_samples.push_back(s);
    end
    drain();
    set_mode(MODE_LINEAR);
    for (int i = 0; i < FrameLen; i++) begin
      s.gap = (i == 0 || i == 3 || i == 4 || i >= FrameLen - 3);
      s.value = (i % 2) ? 16'sh7fff : 16'sh8000;
      pending_samples.push_back(s);
    end
    drain();

    for (int f = 0; f < 4; f++) begin
      set_mode(mode_t'(f % 4));
      if (f == 2) begin
        calm = 1'b1;
        hold_req = 1'b1;
        queue_frame(0);
        queue_frame($urandom_range(10, 80));
        drain();
      end else if (f == 3) begin
        calm = 1'b0;
        queue_frame($urandom_range(10, 80));
        queue_frame($urandom_range(10, 80));
        wait (expected_filled.size() > 0);
        source_pause = 1'b1;
        wait (expected_filled.size() == 0);
        source_pause = 1'b0;
        drain();
      end else begin
        queue_frame(f == 1 ? 100 : $urandom_range(10, 80));
        drain();
      end
    end

    $display("Covered %0d samples in %0d frames over all four fill modes.",
             accepted_samples, frames_done);
    $display("Checked %0d results, including long output stalls.", checked_results);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
